### src/ipdc_pkg.sv
// ipdc_pkg: shared types and constants for the imu packet deframer calibrator
// no dependencies
package ipdc_pkg;
	localparam logic [7:0] HDR_BYTE   = 8'h55;
	localparam logic [7:0] TYPE_ACCEL = 8'h51;
	localparam logic [7:0] TYPE_RATE  = 8'h52;
	localparam logic [7:0] TYPE_ANGLE = 8'h53;
	localparam int unsigned PKT_LEN   = 11;

	typedef enum logic [1:0] {
		KIND_SAMPLE   = 2'd0,
		KIND_CSUM_ERR = 2'd1,
		KIND_BAD_TYPE = 2'd2,
		KIND_CAL_DONE = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		PK_ACCEL = 2'd0,
		PK_RATE  = 2'd1,
		PK_ANGLE = 2'd2,
		PK_OTHER = 2'd3
	} pkt_kind_t;

	// classified packet handed from front to back
	typedef struct packed {
		logic             csum_ok;
		pkt_kind_t        pkind;
		logic signed [15:0] v0;
		logic signed [15:0] v1;
		logic signed [15:0] v2;
	} pkt_t;

	typedef struct packed {
		kind_t              kind;
		logic signed [16:0] accel_x;
		logic signed [16:0] accel_y;
		logic signed [16:0] accel_z;
		logic signed [15:0] rate_x;
		logic signed [15:0] rate_y;
		logic signed [15:0] rate_z;
		logic signed [15:0] roll;
		logic signed [15:0] pitch;
		logic signed [15:0] yaw;
	} res_t;
endpackage

### src/imu_packet_deframer_calibrator.sv
// imu_packet_deframer_calibrator: top level
// a result becomes poppable once the back end's output register and the result queue have taken it
// throughput: one byte per cycle; full rises only while the four-entry result queue,
// counting a word being written into it, has no free slot
// reset: asynchronous active low; framing, freshness, calibration and queue clear
// depends on ipdc_pkg, ipdc_front, ipdc_back, ipdc_fifo
module imu_packet_deframer_calibrator #(
	parameter int CALIB_SAMPLES = 100
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [7:0]         rx_byte,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [14:0]        cfg_data,
	output logic               empty,
	input  logic               pop,
	output logic [1:0]         kind,
	output logic signed [16:0] accel_x,
	output logic signed [16:0] accel_y,
	output logic signed [16:0] accel_z,
	output logic signed [15:0] rate_x,
	output logic signed [15:0] rate_y,
	output logic signed [15:0] rate_z,
	output logic signed [15:0] roll,
	output logic signed [15:0] pitch,
	output logic signed [15:0] yaw
);
	import ipdc_pkg::*;

	logic [14:0] grav_q;
	logic acc, pkt_valid, res_valid, q_full;
	pkt_t pkt;
	res_t res, qd;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) grav_q <= 15'd2048;
		else if (cfg_valid) grav_q <= cfg_data;
	end

	// stall while the queue, with a word being written, has no free slot
	logic [2:0] used_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) used_q <= '0;
		else used_q <= used_q + 3'(res_valid && !q_full) - 3'(pop && !empty);
	end
	assign full = used_q + 3'(res_valid) >= 3'd4;
	assign acc = push && !full;

	ipdc_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(acc), .in_byte(rx_byte),
		.pkt_valid(pkt_valid), .pkt(pkt)
	);

	ipdc_back #(.CALIB_SAMPLES(CALIB_SAMPLES)) u_back (
		.clk(clk), .arst_n(arst_n), .gravity(grav_q), .pkt_valid(pkt_valid),
		.pkt(pkt), .res_valid(res_valid), .res(res)
	);

	ipdc_fifo #(.DEPTH(4)) u_fifo (
		.clk(clk), .arst_n(arst_n), .wr(res_valid && !q_full), .wdata(res),
		.rd(pop && !empty), .empty(empty), .full(q_full), .rdata(qd)
	);

	assign kind = qd.kind;
	assign accel_x = qd.accel_x;
	assign accel_y = qd.accel_y;
	assign accel_z = qd.accel_z;
	assign rate_x = qd.rate_x;
	assign rate_y = qd.rate_y;
	assign rate_z = qd.rate_z;
	assign roll = qd.roll;
	assign pitch = qd.pitch;
	assign yaw = qd.yaw;
endmodule

### src/ipdc_front.sv
// ipdc_front: byte framer, checksum and type classification
// depends on ipdc_pkg
module ipdc_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic [7:0]      in_byte,
	output logic            pkt_valid,
	output ipdc_pkg::pkt_t  pkt
);
	import ipdc_pkg::*;

	logic [3:0] idx_q;
	logic [7:0] sum_q;
	logic [7:0] bytes_q [0:8];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (in_valid) begin
			if (idx_q == 4'd0) begin
				idx_q <= (in_byte == HDR_BYTE) ? 4'd1 : 4'd0;
			end else if (idx_q == 4'(PKT_LEN - 1)) begin
				idx_q <= '0;
			end else begin
				idx_q <= idx_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			if (idx_q == 4'd0) begin
				sum_q <= HDR_BYTE;
			end else begin
				sum_q <= sum_q + in_byte;
			end
			if (idx_q != 4'd0 && idx_q < 4'(PKT_LEN - 1)) begin
				bytes_q[idx_q[3:0] - 4'd1] <= in_byte;
			end
		end
	end

	always_comb begin
		pkt_valid   = in_valid && idx_q == 4'(PKT_LEN - 1);
		pkt.csum_ok = (sum_q == in_byte);
		case (bytes_q[0])
			TYPE_ACCEL: pkt.pkind = PK_ACCEL;
			TYPE_RATE:  pkt.pkind = PK_RATE;
			TYPE_ANGLE: pkt.pkind = PK_ANGLE;
			default:    pkt.pkind = PK_OTHER;
		endcase
		pkt.v0 = {bytes_q[2], bytes_q[1]};
		pkt.v1 = {bytes_q[4], bytes_q[3]};
		pkt.v2 = {bytes_q[6], bytes_q[5]};
	end
endmodule

### src/ipdc_back.sv
// ipdc_back: latest values, calibration and sample assembly
// depends on ipdc_pkg
module ipdc_back #(
	parameter int CALIB_SAMPLES = 100
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [14:0]     gravity,
	input  logic            pkt_valid,
	input  ipdc_pkg::pkt_t  pkt,
	output logic            res_valid,
	output ipdc_pkg::res_t  res
);
	import ipdc_pkg::*;

	// reciprocal of CALIB_SAMPLES for 24-bit magnitudes
	localparam int RSH = 40;
	localparam logic [40:0] RECIP = 41'(((64'd1 << RSH) + CALIB_SAMPLES - 1) / CALIB_SAMPLES);

	logic signed [15:0] acc_q [0:2];
	logic signed [15:0] rate_q [0:2];
	logic signed [15:0] ang_q [0:2];
	logic signed [23:0] csum_q [0:2];
	logic signed [16:0] off_q [0:2];
	logic [3:0] fl_q;
	logic [6:0] cnt_q;

	// calibration divide pipeline
	logic        div_s1, div_s2;
	logic [23:0] mag_s1 [0:2];
	logic        neg_s1 [0:2];
	logic [63:0] prod_s2 [0:2];
	logic        neg_s2 [0:2];
	logic [14:0] grav_s1, grav_s2;

	logic signed [16:0] sat_sum [0:2];
	logic signed [17:0] wide_sum [0:2];
	logic signed [23:0] nsum [0:2];
	logic [6:0] cnt_n;
	logic [3:0] fl_n;
	logic go_cal, emit;

	always_comb begin
		fl_n = fl_q;
		cnt_n = cnt_q;
		go_cal = 1'b0;
		emit = 1'b0;
		for (int i = 0; i < 3; i++) nsum[i] = csum_q[i];
		if (pkt_valid && pkt.csum_ok && pkt.pkind != PK_OTHER) begin
			case (pkt.pkind)
				PK_ACCEL: fl_n[1] = 1'b1;
				PK_RATE:  fl_n[2] = 1'b1;
				PK_ANGLE: fl_n[3] = 1'b1;
				default:  fl_n = fl_q;
			endcase
			if (!fl_n[0]) begin
				if (fl_n[1]) begin
					nsum[0] = csum_q[0] + 24'(pkt.v0);
					nsum[1] = csum_q[1] + 24'(pkt.v1);
					nsum[2] = csum_q[2] + 24'(pkt.v2);
					cnt_n = cnt_q + 7'd1;
					fl_n[1] = 1'b0;
				end
				if (cnt_n >= 7'(CALIB_SAMPLES)) begin
					go_cal = 1'b1;
					fl_n[0] = 1'b1;
				end
			end
			if (!go_cal && fl_n == 4'hF) begin
				emit = 1'b1;
				fl_n = 4'h1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fl_q <= '0;
			cnt_q <= '0;
			div_s1 <= 1'b0;
			div_s2 <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				acc_q[i] <= '0;
				rate_q[i] <= '0;
				ang_q[i] <= '0;
				csum_q[i] <= '0;
				off_q[i] <= '0;
			end
		end else begin
			fl_q <= fl_n;
			cnt_q <= cnt_n;
			div_s1 <= go_cal;
			div_s2 <= div_s1;
			for (int i = 0; i < 3; i++) csum_q[i] <= nsum[i];
			if (pkt_valid && pkt.csum_ok) begin
				case (pkt.pkind)
					PK_ACCEL: begin
						acc_q[0] <= pkt.v0; acc_q[1] <= pkt.v1; acc_q[2] <= pkt.v2;
					end
					PK_RATE: begin
						rate_q[0] <= pkt.v0; rate_q[1] <= pkt.v1; rate_q[2] <= pkt.v2;
					end
					PK_ANGLE: begin
						ang_q[0] <= pkt.v0; ang_q[1] <= pkt.v1; ang_q[2] <= pkt.v2;
					end
					default: begin
					end
				endcase
			end
			if (div_s2) begin
				for (int i = 0; i < 3; i++) begin
					logic signed [17:0] avg;
					avg = neg_s2[i] ? -18'(prod_s2[i][RSH +: 17]) : 18'(prod_s2[i][RSH +: 17]);
					if (i == 2) off_q[i] <= 17'(18'(grav_s2) - avg);
					else        off_q[i] <= 17'(-avg);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		grav_s1 <= gravity;
		grav_s2 <= grav_s1;
		for (int i = 0; i < 3; i++) begin
			neg_s1[i] <= nsum[i][23];
			mag_s1[i] <= nsum[i][23] ? 24'(-nsum[i]) : 24'(nsum[i]);
			neg_s2[i] <= neg_s1[i];
			prod_s2[i] <= 64'(mag_s1[i]) * 64'(RECIP);
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			wide_sum[i] = 18'(acc_q[i]) + 18'(off_q[i]);
			if (wide_sum[i] > 18'sd65535) sat_sum[i] = 17'sd65535;
			else if (wide_sum[i] < -18'sd65536) sat_sum[i] = -17'sd65536;
			else sat_sum[i] = 17'(wide_sum[i]);
		end
	end

	// results leave in the cycle after the packet, so latest values are in place
	logic emit_s1, err_s1;
	kind_t kind_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_s1 <= 1'b0;
			err_s1 <= 1'b0;
		end else begin
			emit_s1 <= emit;
			err_s1 <= pkt_valid && (!pkt.csum_ok || pkt.pkind == PK_OTHER || go_cal);
		end
	end
	always_ff @(posedge clk) begin
		if (!pkt.csum_ok) kind_s1 <= KIND_CSUM_ERR;
		else if (pkt.pkind == PK_OTHER) kind_s1 <= KIND_BAD_TYPE;
		else kind_s1 <= KIND_CAL_DONE;
	end

	always_comb begin
		res_valid = emit_s1 || err_s1;
		res = '0;
		if (emit_s1) begin
			res.kind = KIND_SAMPLE;
			res.accel_x = sat_sum[0];
			res.accel_y = sat_sum[1];
			res.accel_z = sat_sum[2];
			res.rate_x = rate_q[0];
			res.rate_y = rate_q[1];
			res.rate_z = rate_q[2];
			res.roll = ang_q[0];
			res.pitch = ang_q[1];
			res.yaw = ang_q[2];
		end else begin
			res.kind = kind_s1;
		end
	end
endmodule

### src/ipdc_fifo.sv
// ipdc_fifo: small result queue toward the pop side
// depends on ipdc_pkg
module ipdc_fifo #(
	parameter int DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr,
	input  ipdc_pkg::res_t  wdata,
	input  logic            rd,
	output logic            empty,
	output logic            full,
	output ipdc_pkg::res_t  rdata
);
	import ipdc_pkg::*;
	localparam int AW = $clog2(DEPTH);

	res_t mem_q [0:DEPTH-1];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0] cnt_q;

	assign empty = cnt_q == '0;
	assign full  = cnt_q == (AW+1)'(DEPTH);
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			if (rd) rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(wr) - (AW+1)'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wdata;
	end
endmodule

### src/ipdc_checker.sv
// ipdc_checker: port-level checks for the top level
// depends on ipdc_pkg and imu_packet_deframer_calibrator ports
module ipdc_checker (
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic full,
	input logic empty,
	input logic pop,
	input logic [1:0] kind,
	input logic signed [16:0] accel_x
);
	import ipdc_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(kind) && $stable(accel_x)))
		else $error("waiting word changed");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && kind != KIND_SAMPLE) |-> accel_x == '0)
		else $error("error word carries data");
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(empty && !push) |=> !full || $past(full))
		else $error("full rose with nothing pushed");
endmodule

bind imu_packet_deframer_calibrator ipdc_checker u_ipdc_checker (
	.clk(clk), .arst_n(arst_n), .push(push), .full(full), .empty(empty),
	.pop(pop), .kind(kind), .accel_x(accel_x)
);
